FILE: design/hfrc_pkg.sv
// hfrc_pkg: shared constants, types and the byte-wide crc-16 step for the
// hdlc frame receiver with crc check
// no dependencies
`default_nettype none

package hfrc_pkg;

  // framing bytes
  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  // crc seeds
  localparam logic [15:0] InitCcitt  = 16'hFFFF;
  localparam logic [15:0] InitXmodem = 16'h0000;

  // crc polynomials
  localparam logic [15:0] PolyCcittRefl = 16'h8408;
  localparam logic [15:0] PolyXmodem    = 16'h1021;

  // configuration port widths and defaults
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] MaxLenReset = 16'd256;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_LEN  = 8'd0,
    REG_CRC_KIND = 8'd1
  } cfg_reg_e;

  // result event codes
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_FRAME_OK = 2'd1,
    EV_CRC_ERR  = 2'd2,
    EV_OVERFLOW = 2'd3
  } event_e;

  // seed for the selected crc kind
  function automatic logic [15:0] crc_init(input logic kind);
    return kind ? InitXmodem : InitCcitt;
  endfunction

  // one byte through the crc, one bit per step
  function automatic logic [15:0] crc_byte_step(input logic [15:0] crc_in,
                                                input logic [7:0]  b,
                                                input logic        kind);
    logic [15:0] c;
    c = crc_in;
    if (kind) begin
      c = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ PolyXmodem) : {c[14:0], 1'b0};
      end
    end else begin
      c = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
        c = c[0] ? ({1'b0, c[15:1]} ^ PolyCcittRefl) : {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/hdlc_frame_receiver_crc_check.sv
// hdlc_frame_receiver_crc_check: byte-wise hdlc deframer with crc-16 check
// depends on hfrc_pkg
//
// Usage: raw line bytes enter on the s_axis channel, one word per byte. Every
// byte yields exactly one result word on m_axis: the unescaped data byte with
// its index in the frame (tuser bit 0 set), and/or a frame event (frame ok with
// payload length, crc error, overflow) in tuser bits 2:1. Escape bytes, aborts
// and short frames give a result with no data and no event.
// The result is in the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; the deframing, a byte-wide crc
// step and checksum compare sit between the accept edge and the output register.
// The output register frees up in the same cycle it is taken, so input is
// accepted while a result waits as long as m_axis_tready is high that cycle.
// When the downstream stalls, s_axis_tready drops and the held result stays.
// Configuration (cfg_*) is always ready: index 0 max frame length, index 1
// crc kind; writes are meant for idle periods. A new crc kind seeds the crc
// from the next frame restart.
// Reset: frame state cleared, no result held, max length 256, reflected ccitt.
`default_nettype none

module hdlc_frame_receiver_crc_check
  import hfrc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input byte stream
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [39:0]         m_axis_tdata,   // [7:0] data_byte,
                                                   // [23:8] data_index,
                                                   // [39:24] payload_length
  output      logic [2:0]          m_axis_tuser,   // [0] data_valid,
                                                   // [2:1] event_res
  // configuration writes
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [15:0] max_len_q;
  logic        crc_kind_q;

  // frame state
  logic        esc_q, esc_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  recent0_q, recent1_q;
  logic        store_byte;

  // output register
  logic        out_valid_q;
  logic        res_dv_q, res_dv_d;
  logic [7:0]  res_byte_q, res_byte_d;
  logic [15:0] res_idx_q, res_idx_d;
  event_e      res_ev_q, res_ev_d;
  logic [15:0] res_plen_q, res_plen_d;

  logic        in_acc;
  logic [7:0]  b_eff;
  logic [15:0] cnt_inc;
  logic [15:0] rx_crc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MaxLenReset;
      crc_kind_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAX_LEN:  max_len_q  <= cfg_data_i;
        REG_CRC_KIND: crc_kind_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // deframing, crc step and frame check for one byte
  assign b_eff   = esc_q ? (s_axis_tdata ^ EscXor) : s_axis_tdata;
  assign cnt_inc = cnt_q + 16'd1;
  assign rx_crc  = {recent0_q, recent1_q};

  always_comb begin
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    store_byte = 1'b0;
    res_dv_d   = 1'b0;
    res_byte_d = 8'h00;
    res_idx_d  = 16'h0000;
    res_ev_d   = EV_NONE;
    res_plen_d = 16'h0000;
    if (s_axis_tdata == FlagByte) begin
      if (esc_q) begin
        esc_d = 1'b0;
      end else if (cnt_q >= 16'd2) begin
        if (crc_q == rx_crc) begin
          res_ev_d   = EV_FRAME_OK;
          res_plen_d = cnt_q - 16'd2;
        end else begin
          res_ev_d = EV_CRC_ERR;
        end
      end
      cnt_d = 16'h0000;
      crc_d = crc_init(crc_kind_q);
    end else if (!esc_q && s_axis_tdata == EscByte) begin
      esc_d = 1'b1;
    end else begin
      esc_d      = 1'b0;
      store_byte = 1'b1;
      res_dv_d   = 1'b1;
      res_byte_d = b_eff;
      res_idx_d  = cnt_q;
      if (cnt_q >= 16'd2) begin
        crc_d = crc_byte_step(crc_q, recent1_q, crc_kind_q);
      end
      cnt_d = cnt_inc;
      if (cnt_inc >= max_len_q) begin
        cnt_d    = 16'h0000;
        crc_d    = crc_init(crc_kind_q);
        res_ev_d = EV_OVERFLOW;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= 16'h0000;
      crc_q <= InitCcitt;
    end else if (in_acc) begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end

  // last two stored bytes, the received checksum candidates
  always_ff @(posedge clk_i) begin
    if (in_acc && store_byte) begin
      recent1_q <= recent0_q;
      recent0_q <= b_eff;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_dv_q   <= res_dv_d;
      res_byte_q <= res_byte_d;
      res_idx_q  <= res_idx_d;
      res_ev_q   <= res_ev_d;
      res_plen_q <= res_plen_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_plen_q, res_idx_q, res_byte_q};
  assign m_axis_tuser  = {res_ev_q, res_dv_q};

`ifndef SYNTH
  // a flag byte always restarts the frame count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tdata == FlagByte |=> cnt_q == 16'h0000)
    else $error("frame count not cleared after flag byte");

  // a good frame or crc error never carries a data byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[2:1] == EV_FRAME_OK ||
                      m_axis_tuser[2:1] == EV_CRC_ERR) |-> !m_axis_tuser[0])
    else $error("frame event reported together with a data byte");

  // an overflow result restarts the frame count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_ev_d == EV_OVERFLOW |=> cnt_q == 16'h0000 && !esc_q)
    else $error("frame not restarted after overflow");
`endif

endmodule

`default_nettype wire
